@@ rtl/psc_pkg.sv @@
// package: widths, register codes, controller types and saturation helpers for the pid step
`timescale 1ns / 1ps
package psc_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int OPND_W     = DATA_W + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int SH_W       = PROD_W - FRAC_BITS;
  localparam int WIDE_W     = SH_W + 2;
  localparam int LIM_W      = 31;
  localparam int PERIOD_W   = 17;
  localparam int RATE_W     = 31;
  localparam int CFG_ADDR_W = 3;

  localparam logic [LIM_W-1:0]    INTEGRAL_LIMIT_RST   = LIM_W'(39322);
  localparam logic [LIM_W-1:0]    DERIVATIVE_LIMIT_RST = LIM_W'(65536);
  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST    = PERIOD_W'(328);
  localparam logic [RATE_W-1:0]   SAMPLE_RATE_RST      = RATE_W'(13107200);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P           = 3'd0,
    REG_GAIN_I           = 3'd1,
    REG_GAIN_D           = 3'd2,
    REG_INTEGRAL_LIMIT   = 3'd3,
    REG_DERIVATIVE_LIMIT = 3'd4,
    REG_SAMPLE_PERIOD    = 3'd5,
    REG_SAMPLE_RATE      = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic [LIM_W-1:0]         integral_limit;
    logic [LIM_W-1:0]         derivative_limit;
    logic [PERIOD_W-1:0]      sample_period;
    logic [RATE_W-1:0]        sample_rate;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_ERR_PERIOD = 3'd0,
    MUL_DIFF_RATE  = 3'd1,
    MUL_GAIN_P     = 3'd2,
    MUL_GAIN_I     = 3'd3,
    MUL_GAIN_D     = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     diff;
    logic     integ;
    logic     deriv;
    logic     sum_init;
    logic     sum_add;
    logic     finish;
    mul_sel_t mul_sel;
  } dp_cmd_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIFF  = 7'b0000010,
    ST_INTEG = 7'b0000100,
    ST_DERIV = 7'b0001000,
    ST_PROP  = 7'b0010000,
    ST_IGAIN = 7'b0100000,
    ST_DGAIN = 7'b1000000
  } state_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if ((&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1])) begin
      res = v[DATA_W-1:0];
    end else if (v[WIDE_W-1]) begin
      res = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [WIDE_W-1:0] v,
                                                          input logic [LIM_W-1:0] lim);
    logic signed [WIDE_W-1:0] lim_w;
    logic signed [DATA_W-1:0] lim_d;
    logic signed [DATA_W-1:0] res;
    lim_w = signed'({{(WIDE_W-LIM_W){1'b0}}, lim});
    lim_d = signed'({1'b0, lim});
    if (v > lim_w) begin
      res = lim_d;
    end else if (v < -lim_w) begin
      res = -lim_d;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/psc_if.sv @@
// interfaces: input, result and configuration channels of the pid step
`timescale 1ns / 1ps
interface psc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [psc_pkg::DATA_W-1:0]   setpoint;
  logic signed [psc_pkg::DATA_W-1:0]   feedback;
  modport source (output valid, output setpoint, output feedback, input ready);
  modport sink   (input valid, input setpoint, input feedback, output ready);
endinterface

interface psc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [psc_pkg::DATA_W-1:0]   drive;
  logic signed [psc_pkg::DATA_W-1:0]   error_term;
  logic signed [psc_pkg::DATA_W-1:0]   integral_term;
  logic signed [psc_pkg::DATA_W-1:0]   derivative_term;
  modport source (output valid, output drive, output error_term, output integral_term,
                  output derivative_term, input ready);
  modport sink   (input valid, input drive, input error_term, input integral_term,
                  input derivative_term, output ready);
endinterface

interface psc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [psc_pkg::CFG_ADDR_W-1:0]    addr;
  logic [psc_pkg::DATA_W-1:0]        data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ rtl/pid_step_clamped_top.sv @@
// top level: fixed-point pid step with clamped integral and derivative
// input taken in idle, then diff, integ, deriv, prop, igain, dgain states; result registered
// no new input until the last has finished; a single shared 33x33 multiplier is used five times
// a result waiting at the output stalls the final step until it is taken
// reset: synchronous active-low rst_n clears state and error history, loads register defaults
`timescale 1ns / 1ps
module pid_step_clamped_top (
  input logic         clk,
  input logic         rst_n,
  psc_in_if.sink      in_ch,
  psc_out_if.source   out_ch,
  psc_cfg_if.sink     cfg_ch
);

  psc_pkg::cfg_t    cfg;
  psc_pkg::dp_cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  psc_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_addr (cfg_ch.addr),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  psc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .setpoint        (in_ch.setpoint),
    .feedback        (in_ch.feedback),
    .drive           (out_ch.drive),
    .error_term      (out_ch.error_term),
    .integral_term   (out_ch.integral_term),
    .derivative_term (out_ch.derivative_term)
  );

endmodule

@@ rtl/psc_cfg_regs.sv @@
// configuration register file of the pid step
`timescale 1ns / 1ps
module psc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [psc_pkg::CFG_ADDR_W-1:0] wr_addr,
  input  logic [psc_pkg::DATA_W-1:0]     wr_data,
  output psc_pkg::cfg_t                  cfg
);

  psc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p           <= '0;
      cfg_r.gain_i           <= '0;
      cfg_r.gain_d           <= '0;
      cfg_r.integral_limit   <= psc_pkg::INTEGRAL_LIMIT_RST;
      cfg_r.derivative_limit <= psc_pkg::DERIVATIVE_LIMIT_RST;
      cfg_r.sample_period    <= psc_pkg::SAMPLE_PERIOD_RST;
      cfg_r.sample_rate      <= psc_pkg::SAMPLE_RATE_RST;
    end else if (wr_en) begin
      unique case (psc_pkg::cfg_reg_t'(wr_addr))
        psc_pkg::REG_GAIN_P:           cfg_r.gain_p <= signed'(wr_data);
        psc_pkg::REG_GAIN_I:           cfg_r.gain_i <= signed'(wr_data);
        psc_pkg::REG_GAIN_D:           cfg_r.gain_d <= signed'(wr_data);
        psc_pkg::REG_INTEGRAL_LIMIT:   cfg_r.integral_limit <= wr_data[psc_pkg::LIM_W-1:0];
        psc_pkg::REG_DERIVATIVE_LIMIT: cfg_r.derivative_limit <= wr_data[psc_pkg::LIM_W-1:0];
        psc_pkg::REG_SAMPLE_PERIOD:    cfg_r.sample_period <= wr_data[psc_pkg::PERIOD_W-1:0];
        psc_pkg::REG_SAMPLE_RATE:      cfg_r.sample_rate <= wr_data[psc_pkg::RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/psc_ctrl.sv @@
// controller: sequences the shared multiplier and owns the result handshake
`timescale 1ns / 1ps
module psc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output psc_pkg::dp_cmd_t cmd
);

  psc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = psc_pkg::MUL_GAIN_D;
    unique case (state_r)
      psc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = psc_pkg::ST_DIFF;
        end
      end
      psc_pkg::ST_DIFF: begin
        cmd.diff    = 1'b1;
        cmd.mul_sel = psc_pkg::MUL_ERR_PERIOD;
        state_nxt   = psc_pkg::ST_INTEG;
      end
      psc_pkg::ST_INTEG: begin
        cmd.integ   = 1'b1;
        cmd.mul_sel = psc_pkg::MUL_DIFF_RATE;
        state_nxt   = psc_pkg::ST_DERIV;
      end
      psc_pkg::ST_DERIV: begin
        cmd.deriv   = 1'b1;
        cmd.mul_sel = psc_pkg::MUL_GAIN_P;
        state_nxt   = psc_pkg::ST_PROP;
      end
      psc_pkg::ST_PROP: begin
        cmd.sum_init = 1'b1;
        cmd.mul_sel  = psc_pkg::MUL_GAIN_I;
        state_nxt    = psc_pkg::ST_IGAIN;
      end
      psc_pkg::ST_IGAIN: begin
        cmd.sum_add = 1'b1;
        cmd.mul_sel = psc_pkg::MUL_GAIN_D;
        state_nxt   = psc_pkg::ST_DGAIN;
      end
      psc_pkg::ST_DGAIN: begin
        cmd.mul_sel = psc_pkg::MUL_GAIN_D;
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = psc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = psc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == psc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/psc_dp.sv @@
// datapath: error, shared 33x33 multiplier, integral and derivative state, result registers
`timescale 1ns / 1ps
module psc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  psc_pkg::dp_cmd_t                  cmd,
  input  psc_pkg::cfg_t                     cfg,
  input  logic signed [psc_pkg::DATA_W-1:0] setpoint,
  input  logic signed [psc_pkg::DATA_W-1:0] feedback,
  output logic signed [psc_pkg::DATA_W-1:0] drive,
  output logic signed [psc_pkg::DATA_W-1:0] error_term,
  output logic signed [psc_pkg::DATA_W-1:0] integral_term,
  output logic signed [psc_pkg::DATA_W-1:0] derivative_term
);

  localparam int DW = psc_pkg::DATA_W;
  localparam int OW = psc_pkg::OPND_W;
  localparam int PW = psc_pkg::PROD_W;
  localparam int SW = psc_pkg::SH_W;
  localparam int WW = psc_pkg::WIDE_W;

  logic signed [DW-1:0] err_r, diff_r, prev_r, acc_r, integ_r, deriv_r;
  logic signed [PW-1:0] prod_r;
  logic signed [WW-1:0] sum_r;
  logic signed [DW-1:0] drive_r, err_out_r, integ_out_r, deriv_out_r;

  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [DW:0]   err_wide, diff_wide;
  logic signed [SW-1:0] shifted;
  logic signed [WW-1:0] integ_sum, sum_acc;
  logic signed [DW-1:0] integ_val;

  always_comb begin
    case (cmd.mul_sel)
      psc_pkg::MUL_ERR_PERIOD: begin
        mul_a = OW'(err_r);
        mul_b = signed'({{(OW-psc_pkg::PERIOD_W){1'b0}}, cfg.sample_period});
      end
      psc_pkg::MUL_DIFF_RATE: begin
        mul_a = OW'(diff_r);
        mul_b = signed'({{(OW-psc_pkg::RATE_W){1'b0}}, cfg.sample_rate});
      end
      psc_pkg::MUL_GAIN_P: begin
        mul_a = OW'(cfg.gain_p);
        mul_b = OW'(err_r);
      end
      psc_pkg::MUL_GAIN_I: begin
        mul_a = OW'(cfg.gain_i);
        mul_b = OW'(integ_r);
      end
      default: begin
        mul_a = OW'(cfg.gain_d);
        mul_b = OW'(deriv_r);
      end
    endcase
  end

  // floor shift of the product
  assign shifted   = prod_r[PW-1:psc_pkg::FRAC_BITS];
  assign err_wide  = (DW+1)'(setpoint) - (DW+1)'(feedback);
  assign diff_wide = (DW+1)'(err_r) - (DW+1)'(prev_r);
  assign integ_sum = WW'(acc_r) + WW'(shifted);
  assign integ_val = psc_pkg::clamp_sym(WW'(psc_pkg::sat32(integ_sum)), cfg.integral_limit);
  assign sum_acc   = sum_r + WW'(shifted);

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
    if (cmd.load) begin
      err_r <= psc_pkg::sat32(WW'(err_wide));
    end
    if (cmd.diff) begin
      diff_r <= psc_pkg::sat32(WW'(diff_wide));
    end
    if (cmd.integ) begin
      integ_r <= integ_val;
    end
    if (cmd.deriv) begin
      deriv_r <= psc_pkg::clamp_sym(WW'(shifted), cfg.derivative_limit);
    end
    if (cmd.sum_init) begin
      sum_r <= WW'(shifted);
    end else if (cmd.sum_add) begin
      sum_r <= sum_acc;
    end
    if (cmd.finish) begin
      drive_r     <= psc_pkg::sat32(sum_acc);
      err_out_r   <= err_r;
      integ_out_r <= integ_r;
      deriv_out_r <= deriv_r;
    end
  end

  // controller state carried between transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.diff) begin
        prev_r <= err_r;
      end
      if (cmd.integ) begin
        acc_r <= integ_val;
      end
    end
  end

  assign drive           = drive_r;
  assign error_term      = err_out_r;
  assign integral_term   = integ_out_r;
  assign derivative_term = deriv_out_r;

endmodule

@@ rtl/psc_checker.sv @@
// checker: port-level properties of the pid step, bound to the top level
`timescale 1ns / 1ps
module psc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_valid,
  input logic cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second input transaction taken while busy");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |-> ##7 out_valid)
    else $error("result not valid seven cycles after input transaction");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration transaction refused");

endmodule

bind pid_step_clamped_top psc_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready)
);
